[sv/ncpu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the nibble processor core.
// No dependencies; used by nibble_cpu_core_top.
package ncpu_pkg;

  // Sizes
  localparam int unsigned PROGRAM_DEPTH = 256;
  localparam int unsigned SCREEN_SIDE   = 16;
  localparam int unsigned PC_W          = 8;
  localparam int unsigned NIB_W         = 4;
  localparam int unsigned WORD_W        = 3 * NIB_W;
  localparam int unsigned PROG_AW       = $clog2(PROGRAM_DEPTH);
  localparam int unsigned DATA_DEPTH    = 16;
  localparam int unsigned LABEL_DEPTH   = 16;
  localparam int unsigned OUT_DEPTH     = 2;
  localparam int unsigned OUT_PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

  // First program address that is not backed by storage
  localparam logic [PC_W:0] PROG_LIMIT = (PC_W + 1)'(PROGRAM_DEPTH);

  // Request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [NIB_W-1:0] {
    OP_NOP, OP_MVA, OP_MVM, OP_STA, OP_INA, OP_INC, OP_CLS, OP_SHL,
    OP_SHR, OP_RDP, OP_FLP, OP_FLG, OP_JMP, OP_CEQ, OP_CGT, OP_CLT
  } op_e;

  typedef struct packed {
    logic                mode;
    logic [PC_W-1:0]     program_address;
    logic [NIB_W-1:0]    opcode;
    logic [NIB_W-1:0]    first_argument;
    logic [NIB_W-1:0]    second_argument;
    logic [NIB_W-1:0]    arrow_nibble;
    logic [NIB_W-1:0]    row_select;
  } in_req_t;

  typedef struct packed {
    logic [PC_W-1:0]        program_counter_out;
    logic [NIB_W-1:0]       accumulator_out;
    logic [SCREEN_SIDE-1:0] screen_row_bits;
  } out_rsp_t;

  // Pixel x sits at bit SCREEN_SIDE-1-x of a row
  function automatic logic [SCREEN_SIDE-1:0] pixel_mask(input logic [NIB_W-1:0] x);
    return {1'b1, {(SCREEN_SIDE - 1){1'b0}}} >> x;
  endfunction

endpackage

[sv/ncpu_ram.sv]
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, RD_PORTS registered read ports.
// No dependencies.
module ncpu_ram #(
  parameter int unsigned WIDTH    = 8,
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned RD_PORTS = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i [RD_PORTS],
  output logic [WIDTH-1:0]         rdata_o [RD_PORTS]
);

  logic [WIDTH-1:0] mem_q   [DEPTH];
  logic [WIDTH-1:0] rdata_q [RD_PORTS];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RD_PORTS; i++) begin
      rdata_q[i] <= mem_q[raddr_i[i]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/nibble_cpu_core_top.sv]
`timescale 1ns / 1ps
// Top level of the nibble processor core: program, data and screen memories.
// Depends on ncpu_pkg and ncpu_ram.

// A load request writes one 12-bit instruction word to the program memory
// (and, for a label word, its address to the label table); a step request
// executes the instruction at the program counter. Every request returns one
// response with the program counter, the accumulator and the screen row named
// by row_select, all as they stand after that request. No request is taken
// while the previous one is in the fetch stage: the program counter loop runs
// through the program memory read and then the data memory read needed by
// compares before the next fetch address is known. A response is pushed from
// stage 3 into a two-entry output buffer, so a stalled output does not hold
// up the request side until both entries are spoken for.
// No clearing pass is run after reset; the program memory is not cleared and
// must be loaded before it is executed.
module nibble_cpu_core_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ncpu_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ncpu_pkg::out_rsp_t out_rsp_o
);

  // Architectural registers
  logic [ncpu_pkg::PC_W-1:0]        pc_q, pc_d;
  logic [ncpu_pkg::NIB_W-1:0]       acc_q, acc_d;
  logic [ncpu_pkg::PC_W-1:0]        label_q [ncpu_pkg::LABEL_DEPTH];
  logic [ncpu_pkg::DATA_DEPTH-1:0]  dat_vld_q;
  logic [ncpu_pkg::SCREEN_SIDE-1:0] scr_vld_q;

  logic in_accept, out_pop;
  logic [2:0] occ;

  // Stage 1: program word fetch
  logic                       s1_vld_q, s1_mode_q, s1_fetch_ok_q;
  logic [ncpu_pkg::NIB_W-1:0] s1_arrow_q, s1_row_q;
  logic [ncpu_pkg::WORD_W-1:0] word;
  ncpu_pkg::op_e              s1_op;
  logic [ncpu_pkg::NIB_W-1:0] s1_a, s1_b;

  logic                          prog_we;
  logic [ncpu_pkg::PROG_AW-1:0]  prog_waddr;
  logic [ncpu_pkg::WORD_W-1:0]   prog_wdata;
  logic [ncpu_pkg::PROG_AW-1:0]  prog_raddr [1];
  logic [ncpu_pkg::WORD_W-1:0]   prog_rdata [1];

  // Stage 2: data operands, next program counter
  logic                       s2_vld_q, s2_mode_q, s2_xv_q, s2_yv_q;
  ncpu_pkg::op_e              s2_op_q;
  logic [ncpu_pkg::NIB_W-1:0] s2_a_q, s2_arrow_q, s2_row_q;
  logic [ncpu_pkg::NIB_W-1:0] x2, y2;
  logic                       s2_step;

  logic                       dat_we;
  logic [ncpu_pkg::NIB_W-1:0] dat_waddr, dat_wdata;
  logic [ncpu_pkg::NIB_W-1:0] dat_raddr [2];
  logic [ncpu_pkg::NIB_W-1:0] dat_rdata [2];

  // Stage 3: screen, accumulator, response
  logic                       s3_vld_q, s3_mode_q, s3_yvld_q, s3_rvld_q;
  ncpu_pkg::op_e              s3_op_q;
  logic [ncpu_pkg::NIB_W-1:0] s3_a_q, s3_x_q, s3_y_q, s3_arrow_q, s3_row_q;
  logic                       s3_step, do_cls, do_flp, pixel;
  logic [ncpu_pkg::SCREEN_SIDE-1:0] mask3, row_y, row_y_new, row_r, row_out;

  logic                             scr_we;
  logic [ncpu_pkg::NIB_W-1:0]       scr_waddr;
  logic [ncpu_pkg::SCREEN_SIDE-1:0] scr_wdata;
  logic [ncpu_pkg::NIB_W-1:0]       scr_raddr [2];
  logic [ncpu_pkg::SCREEN_SIDE-1:0] scr_rdata [2];

  // Output buffer
  ncpu_pkg::out_rsp_t               fifo_q [ncpu_pkg::OUT_DEPTH];
  logic [ncpu_pkg::OUT_PTR_W-1:0]   fifo_wr_q, fifo_rd_q;
  logic [ncpu_pkg::OUT_CNT_W-1:0]   fifo_cnt_q;
  logic                             fifo_push;

  // Handshake: one request in the fetch stage at a time, and never more
  // requests in flight than the output buffer can hold
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_rsp_o   = fifo_q[fifo_rd_q];
  assign out_pop     = out_valid_o & ~out_stall_i;
  assign occ         = 3'(s2_vld_q) + 3'(s3_vld_q) + 3'(fifo_cnt_q) - 3'(out_pop);
  assign in_stall_o  = s1_vld_q | (occ >= 3'(ncpu_pkg::OUT_DEPTH));
  assign in_accept   = in_valid_i & ~in_stall_o;

  // Program memory: loads write at acceptance, steps read at pc_d
  assign prog_we    = in_accept & (in_req_i.mode == ncpu_pkg::MODE_LOAD) &
                      ({1'b0, in_req_i.program_address} < ncpu_pkg::PROG_LIMIT);
  assign prog_waddr = in_req_i.program_address[ncpu_pkg::PROG_AW-1:0];
  assign prog_wdata = {in_req_i.opcode, in_req_i.first_argument, in_req_i.second_argument};
  assign prog_raddr[0] = pc_d[ncpu_pkg::PROG_AW-1:0];

  ncpu_ram #(
    .WIDTH    (ncpu_pkg::WORD_W),
    .DEPTH    (ncpu_pkg::PROGRAM_DEPTH),
    .RD_PORTS (1)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  // Label table: filled by label loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ncpu_pkg::LABEL_DEPTH; i++) begin
        label_q[i] <= '0;
      end
    end else if (in_accept && in_req_i.mode == ncpu_pkg::MODE_LOAD &&
                 in_req_i.opcode == ncpu_pkg::OP_FLG) begin
      label_q[in_req_i.first_argument] <= in_req_i.program_address;
    end
  end

  // Stage 1 decode; an address past the store reads as a NOP
  assign word  = s1_fetch_ok_q ? prog_rdata[0] : '0;
  assign s1_op = ncpu_pkg::op_e'(word[ncpu_pkg::WORD_W-1 -: ncpu_pkg::NIB_W]);
  assign s1_a  = word[2*ncpu_pkg::NIB_W-1 -: ncpu_pkg::NIB_W];
  assign s1_b  = word[ncpu_pkg::NIB_W-1:0];

  assign dat_raddr[0] = s1_a;
  assign dat_raddr[1] = s1_b;

  ncpu_ram #(
    .WIDTH    (ncpu_pkg::NIB_W),
    .DEPTH    (ncpu_pkg::DATA_DEPTH),
    .RD_PORTS (2)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata)
  );

  // Stage 2: operands, MVM write-back, next program counter
  assign s2_step   = s2_vld_q & (s2_mode_q == ncpu_pkg::MODE_STEP);
  assign x2        = s2_xv_q ? dat_rdata[0] : '0;
  assign y2        = s2_yv_q ? dat_rdata[1] : '0;
  assign dat_we    = s2_step & (s2_op_q == ncpu_pkg::OP_MVM);
  assign dat_waddr = s2_a_q;
  assign dat_wdata = acc_q;

  always_comb begin
    pc_d = pc_q;
    if (s2_step) begin
      unique case (s2_op_q)
        ncpu_pkg::OP_JMP: pc_d = label_q[s2_a_q];
        ncpu_pkg::OP_CEQ: pc_d = pc_q + ((x2 == acc_q) ? 8'd1 : 8'd2);
        ncpu_pkg::OP_CGT: pc_d = pc_q + ((x2 >  acc_q) ? 8'd1 : 8'd2);
        ncpu_pkg::OP_CLT: pc_d = pc_q + ((x2 <  acc_q) ? 8'd1 : 8'd2);
        default:          pc_d = pc_q + 8'd1;
      endcase
    end
  end

  assign scr_raddr[0] = y2;
  assign scr_raddr[1] = s2_row_q;

  ncpu_ram #(
    .WIDTH    (ncpu_pkg::SCREEN_SIDE),
    .DEPTH    (ncpu_pkg::SCREEN_SIDE),
    .RD_PORTS (2)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // Stage 3: pixel work and accumulator
  assign s3_step   = s3_vld_q & (s3_mode_q == ncpu_pkg::MODE_STEP);
  assign do_cls    = s3_step & (s3_op_q == ncpu_pkg::OP_CLS);
  assign do_flp    = s3_step & (s3_op_q == ncpu_pkg::OP_FLP);
  assign mask3     = ncpu_pkg::pixel_mask(s3_x_q);
  assign row_y     = s3_yvld_q ? scr_rdata[0] : '0;
  assign row_y_new = row_y ^ mask3;
  assign pixel     = |(row_y & mask3);
  assign row_r     = s3_rvld_q ? scr_rdata[1] : '0;
  assign scr_we    = do_flp;
  assign scr_waddr = s3_y_q;
  assign scr_wdata = row_y_new;

  // Selected row as it stands after this request
  always_comb begin
    priority if (do_cls) begin
      row_out = '0;
    end else if (do_flp && s3_row_q == s3_y_q) begin
      row_out = row_y_new;
    end else begin
      row_out = row_r;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (s3_step) begin
      unique case (s3_op_q)
        ncpu_pkg::OP_MVA: acc_d = s3_x_q;
        ncpu_pkg::OP_STA: acc_d = s3_a_q;
        ncpu_pkg::OP_INA: acc_d = s3_arrow_q;
        ncpu_pkg::OP_INC: acc_d = acc_q + 4'd1;
        ncpu_pkg::OP_SHL: acc_d = {acc_q[ncpu_pkg::NIB_W-2:0], 1'b0};
        ncpu_pkg::OP_SHR: acc_d = {1'b0, acc_q[ncpu_pkg::NIB_W-1:1]};
        ncpu_pkg::OP_RDP: acc_d = {{(ncpu_pkg::NIB_W - 1){1'b0}}, pixel};
        default:          acc_d = acc_q;
      endcase
    end
  end

  // Control state: stage valids, program counter, accumulator, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      pc_q      <= '0;
      acc_q     <= '0;
      dat_vld_q <= '0;
      scr_vld_q <= '0;
    end else begin
      s1_vld_q <= in_accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      if (dat_we) begin
        dat_vld_q[dat_waddr] <= 1'b1;
      end
      if (do_cls) begin
        scr_vld_q <= '0;
      end else if (do_flp) begin
        scr_vld_q[s3_y_q] <= 1'b1;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    s1_mode_q     <= in_req_i.mode;
    s1_arrow_q    <= in_req_i.arrow_nibble;
    s1_row_q      <= in_req_i.row_select;
    s1_fetch_ok_q <= ({1'b0, pc_d} < ncpu_pkg::PROG_LIMIT);

    s2_mode_q  <= s1_mode_q;
    s2_op_q    <= s1_op;
    s2_a_q     <= s1_a;
    s2_arrow_q <= s1_arrow_q;
    s2_row_q   <= s1_row_q;
    s2_xv_q    <= dat_vld_q[s1_a];
    s2_yv_q    <= dat_vld_q[s1_b];

    s3_mode_q  <= s2_mode_q;
    s3_op_q    <= s2_op_q;
    s3_a_q     <= s2_a_q;
    s3_x_q     <= x2;
    s3_y_q     <= y2;
    s3_arrow_q <= s2_arrow_q;
    s3_row_q   <= s2_row_q;
    s3_yvld_q  <= scr_vld_q[y2];
    s3_rvld_q  <= scr_vld_q[s2_row_q];
  end

  // Output buffer
  assign fifo_push = s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= '0;
      fifo_rd_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wr_q <= fifo_wr_q + 1'b1;
      end
      if (out_pop) begin
        fifo_rd_q <= fifo_rd_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + ncpu_pkg::OUT_CNT_W'(fifo_push)
                    - ncpu_pkg::OUT_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[fifo_wr_q] <= '{program_counter_out: pc_q,
                             accumulator_out:     acc_d,
                             screen_row_bits:     row_out};
    end
  end

`ifndef SYNTHESIS
  // Requests in flight never exceed the output buffer
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(s1_vld_q) + 3'(s2_vld_q) + 3'(s3_vld_q) + 3'(fifo_cnt_q))
      <= 3'(ncpu_pkg::OUT_DEPTH))
    else $error("more requests in flight than output buffer entries");

  // A response is never pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt_q != ncpu_pkg::OUT_CNT_W'(ncpu_pkg::OUT_DEPTH) || out_pop))
    else $error("output buffer overflow");

  // Fetch and operand stages never hold two requests at once
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({s1_vld_q, s2_vld_q}))
    else $error("requests closer than the program counter loop allows");

  // Loads leave the program counter alone
  a_load_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_mode_q == ncpu_pkg::MODE_LOAD) |=> (pc_q == $past(pc_q)))
    else $error("program counter moved on a load");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of nibble_cpu_core_top: loads and runs small programs
// while an in-bench model of the core predicts every response.
// Depends on ncpu_pkg and nibble_cpu_core_top.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ncpu_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ncpu_pkg::out_rsp_t out_rsp_o;

  nibble_cpu_core_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Model copy of the core state
  logic [ncpu_pkg::WORD_W-1:0]      prog_mem    [ncpu_pkg::PROGRAM_DEPTH];
  bit                               prog_loaded [ncpu_pkg::PROGRAM_DEPTH];
  logic [ncpu_pkg::PC_W-1:0]        label_tbl   [ncpu_pkg::LABEL_DEPTH];
  logic [ncpu_pkg::NIB_W-1:0]       data_mem    [ncpu_pkg::DATA_DEPTH];
  logic [ncpu_pkg::SCREEN_SIDE-1:0] screen      [ncpu_pkg::SCREEN_SIDE];
  logic [ncpu_pkg::NIB_W-1:0]       acc;
  logic [ncpu_pkg::PC_W-1:0]        pc;

  ncpu_pkg::out_rsp_t pending_rsp_q[$];
  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Apply one request to the model and return the response it should give
  function automatic ncpu_pkg::out_rsp_t apply_request(input ncpu_pkg::in_req_t req);
    logic [ncpu_pkg::WORD_W-1:0] word;
    ncpu_pkg::op_e               op;
    logic [ncpu_pkg::NIB_W-1:0]  a;
    logic [ncpu_pkg::NIB_W-1:0]  b;
    logic [ncpu_pkg::NIB_W-1:0]  xv;
    logic [ncpu_pkg::NIB_W-1:0]  yv;
    logic [ncpu_pkg::PC_W-1:0]   next_pc;
    ncpu_pkg::out_rsp_t          rsp;
    if (req.mode == ncpu_pkg::MODE_LOAD) begin
      prog_mem[req.program_address]    = {req.opcode, req.first_argument, req.second_argument};
      prog_loaded[req.program_address] = 1'b1;
      // label entry is taken at load time and survives an overwrite
      if (ncpu_pkg::op_e'(req.opcode) == ncpu_pkg::OP_FLG)
        label_tbl[req.first_argument] = req.program_address;
    end else begin
      word    = prog_mem[pc];
      op      = ncpu_pkg::op_e'(word[11:8]);
      a       = word[7:4];
      b       = word[3:0];
      xv      = data_mem[a];
      yv      = data_mem[b];
      next_pc = pc + 8'd1;
      case (op)
        ncpu_pkg::OP_MVA: acc = xv;
        ncpu_pkg::OP_MVM: data_mem[a] = acc;
        ncpu_pkg::OP_STA: acc = a;
        ncpu_pkg::OP_INA: acc = req.arrow_nibble;
        ncpu_pkg::OP_INC: acc = acc + 4'd1;
        ncpu_pkg::OP_CLS: begin
          for (int i = 0; i < ncpu_pkg::SCREEN_SIDE; i++) screen[i] = '0;
        end
        ncpu_pkg::OP_SHL: acc = {acc[2:0], 1'b0};
        ncpu_pkg::OP_SHR: acc = {1'b0, acc[3:1]};
        // column x sits at bit 15-x of its row
        ncpu_pkg::OP_RDP: acc = {3'b000, screen[yv][4'd15 - xv]};
        ncpu_pkg::OP_FLP: screen[yv][4'd15 - xv] = ~screen[yv][4'd15 - xv];
        ncpu_pkg::OP_JMP: next_pc = label_tbl[a];
        // compares skip the next word when they fail
        ncpu_pkg::OP_CEQ: if (xv != acc) next_pc = next_pc + 8'd1;
        ncpu_pkg::OP_CGT: if (xv <= acc) next_pc = next_pc + 8'd1;
        ncpu_pkg::OP_CLT: if (xv >= acc) next_pc = next_pc + 8'd1;
        default: ;
      endcase
      pc = next_pc;
    end
    rsp.program_counter_out = pc;
    rsp.accumulator_out     = acc;
    rsp.screen_row_bits     = screen[req.row_select];
    return rsp;
  endfunction

  // Send one request, with random idle cycles ahead of it
  task automatic send_req(input ncpu_pkg::in_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp_q.push_back(apply_request(req));
    req_cnt++;
  endtask

  task automatic load_word(input logic [ncpu_pkg::PC_W-1:0] addr, input ncpu_pkg::op_e op,
                           input logic [ncpu_pkg::NIB_W-1:0] a,
                           input logic [ncpu_pkg::NIB_W-1:0] b);
    ncpu_pkg::in_req_t req;
    req.mode            = ncpu_pkg::MODE_LOAD;
    req.program_address = addr;
    req.opcode          = op;
    req.first_argument  = a;
    req.second_argument = b;
    req.arrow_nibble    = 4'($urandom);
    req.row_select      = 4'($urandom);
    send_req(req);
  endtask

  task automatic load_random(input logic [ncpu_pkg::PC_W-1:0] addr);
    load_word(addr, ncpu_pkg::op_e'(4'($urandom)), 4'($urandom), 4'($urandom));
  endtask

  // Execute one word; a word never loaded is filled in first
  task automatic step_core(input logic [ncpu_pkg::NIB_W-1:0] arrow,
                           input logic [ncpu_pkg::NIB_W-1:0] row);
    ncpu_pkg::in_req_t req;
    if (!prog_loaded[pc]) load_random(pc);
    req.mode            = ncpu_pkg::MODE_STEP;
    req.program_address = 8'($urandom);
    req.opcode          = 4'($urandom);
    req.first_argument  = 4'($urandom);
    req.second_argument = 4'($urandom);
    req.arrow_nibble    = arrow;
    req.row_select      = row;
    send_req(req);
  endtask

  // Every opcode at least once, with accumulator wrap, dropped top bit and both skip outcomes
  task automatic test_each_opcode();
    load_word(8'd0,  ncpu_pkg::OP_STA, 4'd15, 4'd0);
    load_word(8'd1,  ncpu_pkg::OP_INC, 4'd0,  4'd0);
    load_word(8'd2,  ncpu_pkg::OP_STA, 4'd9,  4'd0);
    load_word(8'd3,  ncpu_pkg::OP_SHL, 4'd0,  4'd0);
    load_word(8'd4,  ncpu_pkg::OP_SHR, 4'd0,  4'd0);
    load_word(8'd5,  ncpu_pkg::OP_MVM, 4'd3,  4'd0);
    load_word(8'd6,  ncpu_pkg::OP_INA, 4'd0,  4'd0);
    load_word(8'd7,  ncpu_pkg::OP_MVM, 4'd15, 4'd0);
    load_word(8'd8,  ncpu_pkg::OP_FLP, 4'd15, 4'd15);
    load_word(8'd9,  ncpu_pkg::OP_RDP, 4'd15, 4'd15);
    load_word(8'd10, ncpu_pkg::OP_MVA, 4'd15, 4'd0);
    load_word(8'd11, ncpu_pkg::OP_CEQ, 4'd15, 4'd0);
    load_word(8'd12, ncpu_pkg::OP_CGT, 4'd3,  4'd0);
    load_word(8'd13, ncpu_pkg::OP_STA, 4'd0,  4'd0);
    load_word(8'd14, ncpu_pkg::OP_CLT, 4'd3,  4'd0);
    load_word(8'd15, ncpu_pkg::OP_NOP, 4'd15, 4'd15);
    load_word(8'd16, ncpu_pkg::OP_CLS, 4'd0,  4'd0);
    load_word(8'd17, ncpu_pkg::OP_FLG, 4'd2,  4'd0);
    load_word(8'd18, ncpu_pkg::OP_JMP, 4'd2,  4'd0);
    repeat (6) step_core(4'd0, 4'd0);
    step_core(4'd15, 4'd15);
    // row 15 shows the flipped pixel until the clear
    repeat (11) step_core(4'd0, 4'd15);
  endtask

  // Program counter wrap by a skip from addresses 254 and 255; label kept after overwrite
  task automatic test_pc_wrap();
    load_word(8'd254, ncpu_pkg::OP_FLG, 4'd7, 4'd0);
    load_word(8'd254, ncpu_pkg::OP_CEQ, 4'd0, 4'd0);
    load_word(8'd255, ncpu_pkg::OP_FLG, 4'd8, 4'd0);
    load_word(8'd255, ncpu_pkg::OP_CGT, 4'd0, 4'd0);
    load_word(8'd17,  ncpu_pkg::OP_JMP, 4'd7, 4'd0);
    load_word(8'd1,   ncpu_pkg::OP_JMP, 4'd8, 4'd0);
    repeat (5) step_core(4'($urandom), 4'($urandom));
  endtask

  // Random programs loaded at the program counter, then run, with stray loads
  task automatic test_random_programs(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned prog_len;
    int unsigned n_steps;
    stop_at = req_cnt + n_items;
    while (req_cnt < stop_at) begin
      prog_len = $urandom_range(3, 20);
      for (int unsigned i = 0; i < prog_len; i++) load_random(pc + 8'(i));
      n_steps = $urandom_range(8, 40);
      for (int unsigned i = 0; i < n_steps; i++) begin
        if ($urandom_range(99) < 8) load_random(8'($urandom));
        step_core(4'($urandom), 4'($urandom));
      end
    end
  endtask

  // Back-to-back traffic on both sides
  task automatic test_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    test_random_programs(80);
    idle_pct  = 18;
    stall_pct = 18;
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    err_cnt++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Response check against the oldest prediction
  always @(posedge clk_i) begin : rsp_check
    ncpu_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 0, 32'(out_rsp_o));
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_rsp_o.program_counter_out !== want.program_counter_out)
          report_mismatch("program_counter_out", 32'(want.program_counter_out),
                          32'(out_rsp_o.program_counter_out));
        if (out_rsp_o.accumulator_out !== want.accumulator_out)
          report_mismatch("accumulator_out", 32'(want.accumulator_out),
                          32'(out_rsp_o.accumulator_out));
        if (out_rsp_o.screen_row_bits !== want.screen_row_bits)
          report_mismatch("screen_row_bits", 32'(want.screen_row_bits),
                          32'(out_rsp_o.screen_row_bits));
      end
    end
  end

  // Random output stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    idle_pct    = 18;
    stall_pct   = 18;
    err_cnt     = 0;
    req_cnt     = 0;
    acc         = '0;
    pc          = '0;
    for (int i = 0; i < ncpu_pkg::PROGRAM_DEPTH; i++) begin
      prog_mem[i]    = '0;
      prog_loaded[i] = 1'b0;
    end
    for (int i = 0; i < 16; i++) begin
      label_tbl[i] = '0;
      data_mem[i]  = '0;
      screen[i]    = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_opcode();
    test_pc_wrap();
    test_random_programs(280);
    test_no_idle();
    test_random_programs(250);

    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ncpu_pkg.sv
sv/ncpu_ram.sv
sv/nibble_cpu_core_top.sv
tb/tb_top.sv
